### rtl/page_fault_frame_replacer_unit_assert.svh
// Assertion macros used by the page-fault frame replacer checker.
`ifndef PAGE_FAULT_FRAME_REPLACER_UNIT_ASSERT_SVH
`define PAGE_FAULT_FRAME_REPLACER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### rtl/pfr_pkg.sv
// Shared types, constants and helper functions of the page-fault frame replacer.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  localparam int unsigned DEF_NUM_FRAMES = 64;
  localparam int unsigned DEF_NUM_PAGES  = 256;

  localparam int unsigned LFSR_W    = 32;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [6:0]  FRAMES_RESET = 7'd64;
  localparam logic [8:0]  PAGES_RESET  = 9'd256;
  localparam logic        POLICY_RESET = 1'b0;
  localparam logic [31:0] SEED_RESET   = 32'd1;

  localparam logic POLICY_FIFO = 1'b0;

  typedef enum logic [2:0] {
    ACT_GRANT_WRITE = 3'd0,
    ACT_NO_CHANGE   = 3'd1,
    ACT_LOAD_FREE   = 3'd2,
    ACT_EVICT_CLEAN = 3'd3,
    ACT_EVICT_DIRTY = 3'd4,
    ACT_NO_VICTIM   = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES = 4'd0,
    REG_PAGES  = 4'd1,
    REG_POLICY = 4'd2,
    REG_SEED   = 4'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DIVIDE,
    S_OWNER_RD,
    S_OWNER,
    S_OWN_ENTRY,
    S_EVICT
  } state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    lfsr_next = s;
  endfunction

endpackage

`default_nettype wire

### rtl/pfr_mod_unit.sv
// Bit-serial remainder unit: reduces the LFSR value modulo the frame count.
`timescale 1ns / 1ps
`default_nettype none

module pfr_mod_unit #(
  parameter int unsigned NUM_FRAMES = pfr_pkg::DEF_NUM_FRAMES
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [pfr_pkg::LFSR_W-1:0]          dividend_i,
  input  wire logic [$clog2(NUM_FRAMES+1)-1:0]     divisor_i,
  output logic                                     done_o,
  output logic [(NUM_FRAMES > 1 ? $clog2(NUM_FRAMES) : 1)-1:0] rem_o
);

  localparam int unsigned FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned FCNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned CNT_W   = $clog2(pfr_pkg::LFSR_W);

  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [pfr_pkg::LFSR_W-1:0] dvd_q, dvd_d;
  logic [FCNT_W-1:0]         rem_q, rem_d;
  logic [FCNT_W:0]           trial;
  logic [FCNT_W:0]           dsr_ext;
  logic [FCNT_W:0]           rem_nxt;

  assign trial   = {rem_q, dvd_q[pfr_pkg::LFSR_W-1]};
  assign dsr_ext = {1'b0, divisor_i};
  assign rem_nxt = (trial >= dsr_ext) ? (trial - dsr_ext) : trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      // one quotient bit per cycle, keep only the partial remainder
      rem_d = rem_nxt[FCNT_W-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(pfr_pkg::LFSR_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[FRAME_W-1:0];

endmodule

`default_nettype wire

### rtl/page_fault_frame_replacer_unit.sv
// Top level of the page-fault frame replacer: page table, reverse frame map and control.
// One fault is taken when start is high and busy is low; its single result appears on the
// result ports for exactly one cycle with result_strobe_o and cannot be held off. A page
// outside the page count answers in the cycle after it is taken; grant-write, no-change and
// free-frame loads answer after one page-table read; a FIFO eviction steps through the
// lookup, owner-read, owner, owner-entry and evict states, reading and writing the page
// table and the frame-to-page map; a random eviction first waits while the LFSR value is
// reduced modulo the frame count one bit per cycle in the serial remainder unit. After reset
// the page table is swept clear, one entry a cycle, and busy stays high until the sweep ends;
// configuration writes are taken at any time and have to be issued while no fault is in flight.
`timescale 1ns / 1ps
`default_nettype none

module page_fault_frame_replacer_unit #(
  parameter int unsigned NUM_FRAMES = pfr_pkg::DEF_NUM_FRAMES,
  parameter int unsigned NUM_PAGES  = pfr_pkg::DEF_NUM_PAGES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [7:0]                    fault_page_i,
  output logic                               result_strobe_o,
  output logic [2:0]                         action_o,
  output logic [5:0]                         frame_o,
  output logic [7:0]                         evicted_page_o,
  output logic                               write_back_o,
  output logic                               read_in_o,
  output logic [31:0]                        fault_total_o,
  output logic [31:0]                        read_total_o,
  output logic [31:0]                        write_total_o
);

  localparam int unsigned FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned FCNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned PTE_W   = FRAME_W + 2;

  // page table entry: {readable, writable, frame}
  logic [PTE_W-1:0]  ptab_mem [NUM_PAGES];
  logic [PAGE_W-1:0] rmap_mem [NUM_FRAMES];

  logic              ptab_we, ptab_re;
  logic [PAGE_W-1:0] ptab_waddr, ptab_raddr;
  logic [PTE_W-1:0]  ptab_wdata, ptab_rdata_q;

  logic               rmap_we, rmap_re;
  logic [FRAME_W-1:0] rmap_waddr, rmap_raddr;
  logic [PAGE_W-1:0]  rmap_wdata, rmap_rdata_q;

  pfr_pkg::state_e    state_q, state_d;
  logic [PAGE_W-1:0]  clr_q, clr_d;
  logic [FCNT_W-1:0]  fill_q, fill_d;
  logic [FRAME_W-1:0] fifo_q, fifo_d;
  logic [31:0]        lfsr_q, lfsr_d;
  logic [31:0]        fault_q, fault_d;
  logic [31:0]        rdc_q, rdc_d;
  logic [31:0]        wrc_q, wrc_d;
  logic [6:0]         frames_q, frames_d;
  logic [8:0]         pages_q, pages_d;
  logic               policy_q, policy_d;
  logic               strobe_q, strobe_d;

  logic [PAGE_W-1:0]  page_q, page_d;
  logic [FRAME_W-1:0] victim_q, victim_d;
  logic [PAGE_W-1:0]  owner_q, owner_d;
  logic               dirty_q, dirty_d;
  pfr_pkg::action_e   action_q, action_d;
  logic [5:0]         frame_q, frame_d;
  logic [7:0]         evict_q, evict_d;
  logic               wb_q, wb_d;
  logic               rin_q, rin_d;

  logic               div_start, div_done;
  logic [31:0]        div_dividend;
  logic [FRAME_W-1:0] div_rem;

  logic [31:0] nf_w, np_w, page_in_w, fill_w, fifo_w, vic_w, vic_inc_w;
  logic [31:0] ent_frame_w, rown_w, own_w;
  logic        ent_rd, ent_wr;

  assign nf_w = (32'(frames_q) > 32'(NUM_FRAMES)) ? 32'(NUM_FRAMES) : 32'(frames_q);
  assign np_w = (32'(pages_q) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : 32'(pages_q);

  assign page_in_w   = 32'(fault_page_i);
  assign fill_w      = 32'(fill_q);
  assign fifo_w      = 32'(fifo_q);
  assign vic_w       = 32'(victim_q);
  assign vic_inc_w   = vic_w + 32'd1;
  assign ent_frame_w = 32'(ptab_rdata_q[FRAME_W-1:0]);
  assign rown_w      = 32'(rmap_rdata_q);
  assign own_w       = 32'(owner_q);
  assign ent_rd      = ptab_rdata_q[PTE_W-1];
  assign ent_wr      = ptab_rdata_q[PTE_W-2];

  assign div_dividend = pfr_pkg::lfsr_next(lfsr_q);

  pfr_mod_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (nf_w[FCNT_W-1:0]),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    fill_d   = fill_q;
    fifo_d   = fifo_q;
    lfsr_d   = lfsr_q;
    fault_d  = fault_q;
    rdc_d    = rdc_q;
    wrc_d    = wrc_q;
    frames_d = frames_q;
    pages_d  = pages_q;
    policy_d = policy_q;
    strobe_d = 1'b0;
    page_d   = page_q;
    victim_d = victim_q;
    owner_d  = owner_q;
    dirty_d  = dirty_q;
    action_d = action_q;
    frame_d  = frame_q;
    evict_d  = evict_q;
    wb_d     = wb_q;
    rin_d    = rin_q;

    ptab_we    = 1'b0;
    ptab_waddr = page_q;
    ptab_wdata = '0;
    ptab_re    = 1'b0;
    ptab_raddr = page_q;
    rmap_we    = 1'b0;
    rmap_waddr = victim_q;
    rmap_wdata = page_q;
    rmap_re    = 1'b0;
    rmap_raddr = victim_q;
    div_start  = 1'b0;

    unique case (state_q)
      pfr_pkg::S_CLEAR: begin
        ptab_we    = 1'b1;
        ptab_waddr = clr_q;
        clr_d      = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = pfr_pkg::S_IDLE;
        end
      end
      pfr_pkg::S_IDLE: begin
        if (start) begin
          fault_d = pfr_pkg::sat_inc(fault_q);
          page_d  = page_in_w[PAGE_W-1:0];
          if (page_in_w < np_w) begin
            ptab_re    = 1'b1;
            ptab_raddr = page_in_w[PAGE_W-1:0];
            state_d    = pfr_pkg::S_LOOKUP;
          end else begin
            strobe_d = 1'b1;
            action_d = pfr_pkg::ACT_NO_VICTIM;
            frame_d  = '0;
            evict_d  = '0;
            wb_d     = 1'b0;
            rin_d    = 1'b0;
          end
        end
      end
      pfr_pkg::S_LOOKUP: begin
        state_d = pfr_pkg::S_IDLE;
        evict_d = '0;
        wb_d    = 1'b0;
        rin_d   = 1'b0;
        if (ent_rd && !ent_wr) begin
          ptab_we    = 1'b1;
          ptab_wdata = {2'b11, ptab_rdata_q[FRAME_W-1:0]};
          strobe_d   = 1'b1;
          action_d   = pfr_pkg::ACT_GRANT_WRITE;
          frame_d    = ent_frame_w[5:0];
        end else if (ent_rd) begin
          strobe_d = 1'b1;
          action_d = pfr_pkg::ACT_NO_CHANGE;
          frame_d  = ent_frame_w[5:0];
        end else if (fill_w < nf_w) begin
          // frames fill in order, so the lowest free frame is the fill count
          ptab_we    = 1'b1;
          ptab_wdata = {2'b10, fill_q[FRAME_W-1:0]};
          rmap_we    = 1'b1;
          rmap_waddr = fill_q[FRAME_W-1:0];
          fill_d     = fill_q + FCNT_W'(1);
          rdc_d      = pfr_pkg::sat_inc(rdc_q);
          strobe_d   = 1'b1;
          action_d   = pfr_pkg::ACT_LOAD_FREE;
          frame_d    = fill_w[5:0];
          rin_d      = 1'b1;
        end else if (nf_w == 32'd0) begin
          strobe_d = 1'b1;
          action_d = pfr_pkg::ACT_NO_VICTIM;
          frame_d  = '0;
        end else if (policy_q != pfr_pkg::POLICY_FIFO) begin
          lfsr_d    = div_dividend;
          div_start = 1'b1;
          state_d   = pfr_pkg::S_DIVIDE;
        end else begin
          victim_d = (fifo_w < nf_w) ? fifo_q : '0;
          state_d  = pfr_pkg::S_OWNER_RD;
        end
      end
      pfr_pkg::S_DIVIDE: begin
        if (div_done) begin
          victim_d = div_rem;
          state_d  = pfr_pkg::S_OWNER_RD;
        end
      end
      pfr_pkg::S_OWNER_RD: begin
        rmap_re = 1'b1;
        state_d = pfr_pkg::S_OWNER;
      end
      pfr_pkg::S_OWNER: begin
        if (vic_w < fill_w && rown_w < np_w) begin
          owner_d    = rmap_rdata_q;
          ptab_re    = 1'b1;
          ptab_raddr = rmap_rdata_q;
          state_d    = pfr_pkg::S_OWN_ENTRY;
        end else begin
          // victim frame never filled or owner beyond the page count: leave everything in place
          strobe_d = 1'b1;
          action_d = pfr_pkg::ACT_NO_VICTIM;
          frame_d  = '0;
          evict_d  = '0;
          wb_d     = 1'b0;
          rin_d    = 1'b0;
          state_d  = pfr_pkg::S_IDLE;
        end
      end
      pfr_pkg::S_OWN_ENTRY: begin
        dirty_d    = ent_wr;
        ptab_we    = 1'b1;
        ptab_waddr = owner_q;
        ptab_wdata = '0;
        state_d    = pfr_pkg::S_EVICT;
      end
      pfr_pkg::S_EVICT: begin
        ptab_we    = 1'b1;
        ptab_wdata = {2'b10, victim_q};
        rmap_we    = 1'b1;
        rdc_d      = pfr_pkg::sat_inc(rdc_q);
        if (dirty_q) begin
          wrc_d = pfr_pkg::sat_inc(wrc_q);
        end
        if (policy_q == pfr_pkg::POLICY_FIFO) begin
          fifo_d = (vic_inc_w == nf_w) ? '0 : vic_inc_w[FRAME_W-1:0];
        end
        strobe_d = 1'b1;
        action_d = dirty_q ? pfr_pkg::ACT_EVICT_DIRTY : pfr_pkg::ACT_EVICT_CLEAN;
        frame_d  = vic_w[5:0];
        evict_d  = own_w[7:0];
        wb_d     = dirty_q;
        rin_d    = 1'b1;
        state_d  = pfr_pkg::S_IDLE;
      end
      default: begin
        state_d = pfr_pkg::S_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pfr_pkg::REG_FRAMES: frames_d = cfg_data_i[6:0];
        pfr_pkg::REG_PAGES:  pages_d  = cfg_data_i[8:0];
        pfr_pkg::REG_POLICY: policy_d = cfg_data_i[0];
        pfr_pkg::REG_SEED:   lfsr_d   = cfg_data_i;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfr_pkg::S_CLEAR;
      clr_q    <= '0;
      fill_q   <= '0;
      fifo_q   <= '0;
      lfsr_q   <= pfr_pkg::SEED_RESET;
      fault_q  <= '0;
      rdc_q    <= '0;
      wrc_q    <= '0;
      frames_q <= pfr_pkg::FRAMES_RESET;
      pages_q  <= pfr_pkg::PAGES_RESET;
      policy_q <= pfr_pkg::POLICY_RESET;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      fill_q   <= fill_d;
      fifo_q   <= fifo_d;
      lfsr_q   <= lfsr_d;
      fault_q  <= fault_d;
      rdc_q    <= rdc_d;
      wrc_q    <= wrc_d;
      frames_q <= frames_d;
      pages_q  <= pages_d;
      policy_q <= policy_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q   <= page_d;
    victim_q <= victim_d;
    owner_q  <= owner_d;
    dirty_q  <= dirty_d;
    action_q <= action_d;
    frame_q  <= frame_d;
    evict_q  <= evict_d;
    wb_q     <= wb_d;
    rin_q    <= rin_d;
  end

  always_ff @(posedge clk_i) begin
    if (ptab_we) begin
      ptab_mem[ptab_waddr] <= ptab_wdata;
    end
    if (ptab_re) begin
      ptab_rdata_q <= ptab_mem[ptab_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rmap_we) begin
      rmap_mem[rmap_waddr] <= rmap_wdata;
    end
    if (rmap_re) begin
      rmap_rdata_q <= rmap_mem[rmap_raddr];
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign busy            = (state_q != pfr_pkg::S_IDLE);
  assign result_strobe_o = strobe_q;
  assign action_o        = action_q;
  assign frame_o         = frame_q;
  assign evicted_page_o  = evict_q;
  assign write_back_o    = wb_q;
  assign read_in_o       = rin_q;
  assign fault_total_o   = fault_q;
  assign read_total_o    = rdc_q;
  assign write_total_o   = wrc_q;

endmodule

`default_nettype wire

### rtl/pfr_checker.sv
// Port-level checker for the page-fault frame replacer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "page_fault_frame_replacer_unit_assert.svh"

module pfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_strobe_o,
  input wire logic [2:0]  action_o,
  input wire logic        write_back_o,
  input wire logic        read_in_o,
  input wire logic [31:0] fault_total_o,
  input wire logic [31:0] read_total_o,
  input wire logic [31:0] write_total_o
);

  // an accepted fault either answers at once or keeps the block busy
  `PFR_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || result_strobe_o)

  // a result always leaves the block ready for the next transaction
  `PFR_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, result_strobe_o, !busy)

  // a write-back only comes with a dirty eviction that also reads the new page
  `PFR_ASSERT_IMP(a_wb_dirty, clk_i, rst_ni, result_strobe_o && write_back_o, read_in_o && action_o == pfr_pkg::ACT_EVICT_DIRTY)

  // each fault orders at most one read, each read at most one write
  `PFR_ASSERT_IMP(a_totals_order, clk_i, rst_ni, result_strobe_o, read_total_o <= fault_total_o && write_total_o <= read_total_o)

endmodule

bind page_fault_frame_replacer_unit pfr_checker u_pfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .action_o        (action_o),
  .write_back_o    (write_back_o),
  .read_in_o       (read_in_o),
  .fault_total_o   (fault_total_o),
  .read_total_o    (read_total_o),
  .write_total_o   (write_total_o)
);

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the page-fault frame replacer unit.
`timescale 1ns / 1ps

module tb;
  import pfr_pkg::*;

  localparam int unsigned FRAME_CAP       = DEF_NUM_FRAMES;
  localparam int unsigned PAGE_CAP        = DEF_NUM_PAGES;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned SETTLE_CYCLES   = 60;
  localparam int unsigned REPORT_MAX      = 10;

  typedef struct packed {
    action_e     action;
    logic [5:0]  frame;
    logic [7:0]  evicted;
    logic        write_back;
    logic        read_in;
    logic [31:0] faults;
    logic [31:0] reads;
    logic [31:0] writes;
  } disk_cmd_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    sel;
    logic [31:0] data;
    logic [7:0]  page;
    bit          pinned;
    disk_cmd_t   want;
  } plan_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic [7:0]           fault_page_i = '0;
  logic                 result_strobe_o;
  logic [2:0]           action_o;
  logic [5:0]           frame_o;
  logic [7:0]           evicted_page_o;
  logic                 write_back_o;
  logic                 read_in_o;
  logic [31:0]          fault_total_o;
  logic [31:0]          read_total_o;
  logic [31:0]          write_total_o;

  page_fault_frame_replacer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start           (start),
    .busy            (busy),
    .fault_page_i    (fault_page_i),
    .result_strobe_o (result_strobe_o),
    .action_o        (action_o),
    .frame_o         (frame_o),
    .evicted_page_o  (evicted_page_o),
    .write_back_o    (write_back_o),
    .read_in_o       (read_in_o),
    .fault_total_o   (fault_total_o),
    .read_total_o    (read_total_o),
    .write_total_o   (write_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow page table and replacement state
  bit [5:0]  table_frame [PAGE_CAP];
  bit        table_read  [PAGE_CAP];
  bit        table_write [PAGE_CAP];
  bit        frame_taken [FRAME_CAP];
  bit [5:0]  next_victim = '0;
  bit [31:0] lfsr_state  = SEED_RESET;
  bit [31:0] n_faults    = '0;
  bit [31:0] n_reads     = '0;
  bit [31:0] n_writes    = '0;
  bit [6:0]  cfg_frames  = FRAMES_RESET;
  bit [8:0]  cfg_pages   = PAGES_RESET;
  bit        cfg_policy  = POLICY_RESET;

  logic        pin_valid = 1'b0;
  disk_cmd_t   pin_res   = '0;
  disk_cmd_t   cmd_q[$];
  plan_row_t   plan[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned burst_left = 4;

  function automatic bit [31:0] bump(input bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int unsigned live_frames();
    return (cfg_frames > FRAME_CAP) ? FRAME_CAP : cfg_frames;
  endfunction

  function automatic int unsigned live_pages();
    return (cfg_pages > PAGE_CAP) ? PAGE_CAP : cfg_pages;
  endfunction

  function automatic disk_cmd_t resolve_fault(input logic [7:0] page);
    disk_cmd_t   r;
    int unsigned nf;
    int unsigned np;
    int unsigned victim;
    int unsigned i;
    bit          done;
    r        = '0;
    r.action = ACT_NO_VICTIM;
    nf       = live_frames();
    np       = live_pages();
    done     = 1'b0;
    n_faults = bump(n_faults);
    if (page < np) begin
      if (table_read[page]) begin
        r.frame = table_frame[page];
        if (!table_write[page]) begin
          table_write[page] = 1'b1;
          r.action          = ACT_GRANT_WRITE;
        end else begin
          r.action = ACT_NO_CHANGE;
        end
        done = 1'b1;
      end
      for (i = 0; !done && i < nf; i++) begin
        if (!frame_taken[i]) begin
          table_frame[page] = i[5:0];
          table_read[page]  = 1'b1;
          table_write[page] = 1'b0;
          frame_taken[i]    = 1'b1;
          n_reads           = bump(n_reads);
          r.action          = ACT_LOAD_FREE;
          r.frame           = i[5:0];
          r.read_in         = 1'b1;
          done              = 1'b1;
        end
      end
      if (!done && nf > 0) begin
        if (cfg_policy) begin
          lfsr_state = (lfsr_state >> 1) ^ (lfsr_state[0] ? LFSR_TAPS : 32'd0);
          victim     = lfsr_state % nf;
        end else begin
          victim = (next_victim < nf) ? next_victim : 0;
        end
        // Scan for the owner of the victim frame; no owner means no victim
        for (i = 0; !done && i < np; i++) begin
          if (table_read[i] && table_frame[i] == victim) begin
            if (table_write[i]) begin
              n_writes     = bump(n_writes);
              r.write_back = 1'b1;
              r.action     = ACT_EVICT_DIRTY;
            end else begin
              r.action = ACT_EVICT_CLEAN;
            end
            table_frame[i]    = '0;
            table_read[i]     = 1'b0;
            table_write[i]    = 1'b0;
            table_frame[page] = victim[5:0];
            table_read[page]  = 1'b1;
            table_write[page] = 1'b0;
            n_reads           = bump(n_reads);
            r.read_in         = 1'b1;
            r.frame           = victim[5:0];
            r.evicted         = i[7:0];
            if (!cfg_policy) next_victim = 6'((victim + 1) % nf);
            done = 1'b1;
          end
        end
      end
    end
    r.faults = n_faults;
    r.reads  = n_reads;
    r.writes = n_writes;
    return r;
  endfunction

  function automatic string cmd_text(input disk_cmd_t c);
    return $sformatf("act=%0d frame=%0d evicted=%0d wb=%0b rd=%0b faults=%0d reads=%0d writes=%0d",
                     c.action, c.frame, c.evicted, c.write_back, c.read_in,
                     c.faults, c.reads, c.writes);
  endfunction

  // Check each strobed result, then predict the transaction accepted on this edge
  always @(posedge clk_i) begin
    disk_cmd_t got;
    disk_cmd_t want;
    if (rst_ni) begin
      if (result_strobe_o) begin
        got = {action_e'(action_o), frame_o, evicted_page_o, write_back_o, read_in_o,
               fault_total_o, read_total_o, write_total_o};
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) $display("unexpected result: %s", cmd_text(got));
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("mismatch: expected %s", cmd_text(want));
              $display("          actual   %s", cmd_text(got));
            end
          end
        end
      end
      if (start && !busy) begin
        want = resolve_fault(fault_page_i);
        cmd_q.push_back(pin_valid ? pin_res : want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("page_fault_frame_replacer_unit regression: fail");
      $finish;
    end
  end

  // Wait until nothing is in flight; return on a rising edge
  task automatic settle();
    do @(negedge clk_i); while (cmd_q.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (sel)
      REG_FRAMES: cfg_frames = val[6:0];
      REG_PAGES:  cfg_pages  = val[8:0];
      REG_POLICY: cfg_policy = val[0];
      REG_SEED:   lfsr_state = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_fault(input logic [7:0] page, input bit pinned, input disk_cmd_t want);
    start        <= 1'b1;
    fault_page_i <= page;
    pin_valid    <= pinned;
    pin_res      <= want;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold start high through a burst, drop it for a random gap between bursts
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic add_cfg(input cfg_reg_e sel, input logic [31:0] val);
    plan_row_t row;
    row        = '{sel: REG_FRAMES, default: '0};
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.data   = val;
    plan.push_back(row);
  endtask

  task automatic add_fault(input logic [7:0] page);
    plan_row_t row;
    row      = '{sel: REG_FRAMES, default: '0};
    row.sel  = REG_FRAMES;
    row.page = page;
    plan.push_back(row);
  endtask

  task automatic add_check(input logic [7:0] page, input action_e act, input logic [5:0] frame,
                           input logic [7:0] evicted, input logic wb, input logic rin,
                           input int unsigned faults, input int unsigned reads,
                           input int unsigned writes);
    plan_row_t row;
    row        = '{sel: REG_FRAMES, default: '0};
    row.sel    = REG_FRAMES;
    row.page   = page;
    row.pinned = 1'b1;
    row.want   = {act, frame, evicted, wb, rin, faults, reads, writes};
    plan.push_back(row);
  endtask

  initial begin
    int unsigned nf;
    int unsigned np;
    int unsigned hot;
    int unsigned pick;
    logic [6:0]  frames;
    logic [8:0]  pages;
    logic        policy;
    logic [31:0] seed;
    logic [7:0]  page;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait out the page-table sweep after reset
    settle();

    // Fill four frames from reset, with hits on the first page, then shrink the tables to force corner cases
    add_check(8'd0,   ACT_LOAD_FREE,   6'd0, 8'd0, 1'b0, 1'b1, 1, 1, 0);
    add_check(8'd0,   ACT_GRANT_WRITE, 6'd0, 8'd0, 1'b0, 1'b0, 2, 1, 0);
    add_check(8'd0,   ACT_NO_CHANGE,   6'd0, 8'd0, 1'b0, 1'b0, 3, 1, 0);
    add_check(8'd255, ACT_LOAD_FREE,   6'd1, 8'd0, 1'b0, 1'b1, 4, 2, 0);
    add_check(8'hAA,  ACT_LOAD_FREE,   6'd2, 8'd0, 1'b0, 1'b1, 5, 3, 0);
    add_check(8'h55,  ACT_LOAD_FREE,   6'd3, 8'd0, 1'b0, 1'b1, 6, 4, 0);
    add_cfg(REG_PAGES, 32'd16);
    add_check(8'd255, ACT_NO_VICTIM,   6'd0, 8'd0, 1'b0, 1'b0, 7, 4, 0);
    add_cfg(REG_FRAMES, 32'd4);
    add_check(8'd1,   ACT_EVICT_DIRTY, 6'd0, 8'd0, 1'b1, 1'b1, 8, 5, 1);
    // Frame 1 belongs to a page outside the page count: no owner found
    add_check(8'd2,   ACT_NO_VICTIM,   6'd0, 8'd0, 1'b0, 1'b0, 9, 5, 1);
    add_cfg(REG_PAGES, 32'd256);
    add_check(8'd2,   ACT_EVICT_CLEAN, 6'd1, 8'd255, 1'b0, 1'b1, 10, 6, 1);
    add_cfg(REG_FRAMES, 32'd0);
    add_check(8'd3,   ACT_NO_VICTIM,   6'd0, 8'd0, 1'b0, 1'b0, 11, 6, 1);
    add_check(8'd1,   ACT_GRANT_WRITE, 6'd0, 8'd0, 1'b0, 1'b0, 12, 6, 1);
    add_cfg(REG_FRAMES, 32'd127);
    add_check(8'd3,   ACT_LOAD_FREE,   6'd4, 8'd0, 1'b0, 1'b1, 13, 7, 1);
    // Pointer now sits past the frame count, so frame 0 is the victim
    add_cfg(REG_FRAMES, 32'd2);
    add_check(8'd4,   ACT_EVICT_DIRTY, 6'd0, 8'd1, 1'b1, 1'b1, 14, 8, 2);
    add_cfg(REG_POLICY, 32'd1);
    add_cfg(REG_SEED, 32'd0);
    add_check(8'd5,   ACT_EVICT_CLEAN, 6'd0, 8'd4, 1'b0, 1'b1, 15, 9, 2);
    add_cfg(REG_SEED, 32'd1);
    add_check(8'd6,   ACT_EVICT_CLEAN, 6'd1, 8'd2, 1'b0, 1'b1, 16, 10, 2);
    add_cfg(REG_PAGES, 32'd511);
    add_fault(8'd255);
    add_fault(8'd128);
    add_cfg(REG_SEED, 32'hFFFF_FFFF);
    add_fault(8'd7);
    add_fault(8'h7F);
    add_fault(8'd9);
    add_cfg(REG_POLICY, 32'd0);
    add_fault(8'd10);
    add_fault(8'd6);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        start <= 1'b0;
        settle();
        write_reg(plan[k].sel, plan[k].data);
      end else begin
        send_fault(plan[k].page, plan[k].pinned, plan[k].want);
        pace();
      end
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin frames = 7'd1;  pages = 9'd1;   policy = 1'b0; seed = $urandom(); end
        1: begin frames = 7'd64; pages = 9'd256; policy = 1'b1; seed = 32'hFFFF_FFFF; end
        2: begin frames = 7'd3;  pages = 9'd20;  policy = 1'b0; seed = $urandom(); end
        default: begin
          pick   = $urandom_range(0, 9);
          frames = (pick == 0) ? 7'd0 : (pick == 1) ? 7'($urandom_range(65, 127)) :
                   (pick == 2) ? 7'd64 : 7'($urandom_range(1, 12));
          pick   = $urandom_range(0, 9);
          pages  = (pick == 0) ? 9'd0 : (pick == 1) ? 9'($urandom_range(257, 511)) :
                   (pick == 2) ? 9'd256 : 9'($urandom_range(2, 48));
          policy = 1'($urandom_range(0, 1));
          seed   = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom();
        end
      endcase
      start <= 1'b0;
      settle();
      write_reg(REG_FRAMES, {25'd0, frames});
      write_reg(REG_PAGES, {23'd0, pages});
      write_reg(REG_POLICY, {31'd0, policy});
      write_reg(REG_SEED, seed);

      // Keep most faults inside a working set of twice the frame pool plus four, capped at the page count
      nf  = live_frames();
      np  = live_pages();
      hot = 2 * ((nf == 0) ? 1 : nf) + 4;
      if (hot > np) hot = np;
      if (hot == 0) hot = 1;

      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        page = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
                                             8'($urandom_range(0, hot - 1));
        send_fault(page, 1'b0, '0);
        if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 99) == 0) begin
          start <= 1'b0;
          settle();
        end else begin
          pace();
        end
      end
    end

    start <= 1'b0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (cmd_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("page_fault_frame_replacer_unit regression: pass");
    end else begin
      $display("page_fault_frame_replacer_unit regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/pfr_pkg.sv
rtl/pfr_mod_unit.sv
rtl/page_fault_frame_replacer_unit.sv
rtl/pfr_checker.sv
sim/tb.sv
